FILE: hdl/assert_macros.svh
// assert_macros.svh: concurrent assertion macros for the RTL in this folder.
// Depends on nothing; expands to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define RGEM_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// antecedent implies consequent in the next cycle
`define RGEM_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RGEM_ASSERT_IMP(label, clk, rst, ante, cons)
`define RGEM_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: hdl/rgem_pkg.sv
// rgem_pkg: word types, register codes and constants of the gradient energy map.
// Depends on nothing; used by rgb_gradient_energy_map.
package rgem_pkg;

   localparam int MAX_WIDTH_DFLT = 2048;

   localparam logic [11:0] WIDTH_RESET  = 12'd640;
   localparam logic [15:0] HEIGHT_RESET = 16'd480;

   localparam int FULL_DELTA = 1530;
   localparam int HALF_DELTA = FULL_DELTA / 2;
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // floor(sum * 2^15 / 765) == (sum * RECIP) >> RECIP_SHIFT for every sum up to 1530
   localparam int RECIP_EXP   = 36;
   localparam int RECIP_SHIFT = RECIP_EXP - 15;
   localparam int RECIP_W     = 27;
   localparam int PROD_W      = RECIP_W + 11;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << RECIP_EXP) + 64'(HALF_DELTA) - 64'd1) / 64'(HALF_DELTA));

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_word_type;

   typedef struct packed {
      logic [15:0] out_row;
      logic [10:0] out_col;
      logic [10:0] gradient_sum;
      logic [16:0] energy_q16;
      logic        on_border;
      logic        frame_end;
      logic        last_of_run;
   } rsp_word_type;

   typedef struct packed {
      logic [15:0] row;
      logic [10:0] col;
      logic        emit_a;
      logic        emit_b;
      logic        border_a;
      logic        last_col;
   } ctrl_type;

   function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
      absdiff = (a > b) ? (a - b) : (b - a);
   endfunction

endpackage

FILE: hdl/rgb_gradient_energy_map.sv
// Top level: streaming L1 gradient energy over RGB pixels in raster order.
// A result passes the stage 1 and stage 2 registers into the stage 3 output register.
// One word per cycle while rsp_stall is low; a word on the last row other than row 0
// yields two results, so the output register stalls the input until the second is
// taken. The line buffer with two read ports (here and right) sets the rate. Reset
// (synchronous) clears counters, pipeline valids and registers to 640 x 480; line buffers are not cleared.
`include "assert_macros.svh"

module rgb_gradient_energy_map #(
   parameter int MAX_WIDTH = rgem_pkg::MAX_WIDTH_DFLT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  rgem_pkg::req_word_type   req_word,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rgem_pkg::rsp_word_type   rsp_word,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  rgem_pkg::csr_index_type  csr_index,
   input  logic [15:0]              csr_data
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic [11:0]            width_ff, width_in;
   logic [15:0]            height_ff, height_in;
   logic [CW-1:0]          col_ff, col_in, col_nx, last_col_idx;
   logic [15:0]            row_ff, row_in, prev_row, last_row_idx;
   logic                   last_col, last_row, adv, acc;
   rgem_pkg::ctrl_type     ctrl0;

   rgem_pkg::req_word_type above_mem [MAX_WIDTH];
   rgem_pkg::req_word_type two_mem [MAX_WIDTH];
   rgem_pkg::req_word_type above_ff, right_ff, two_ff;

   logic                   valid1_ff, fwd_ff;
   rgem_pkg::ctrl_type     ctrl1_ff;
   rgem_pkg::req_word_type px1_ff, fwd_px_ff, held_ff, two_px;
   logic [CW-1:0]          addr1_ff;
   logic [10:0]            sum1;

   logic                   valid2_ff;
   rgem_pkg::ctrl_type     ctrl2_ff;
   logic [10:0]            sum2_ff;
   logic [rgem_pkg::PROD_W-1:0] prod2;
   logic [16:0]            energy2;

   logic                   valid3_ff, valid3_in, phase_ff, phase_in;
   rgem_pkg::ctrl_type     ctrl3_ff;
   logic [10:0]            sum3_ff;
   logic [16:0]            energy3_ff;
   logic                   sel_b, last_pend;

   // configuration
   assign csr_ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            rgem_pkg::CSR_IMAGE_WIDTH:  width_in  = csr_data[11:0];
            rgem_pkg::CSR_IMAGE_HEIGHT: height_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (width_ff == 12'd0) begin
         last_col_idx = '0;
      end else if ({20'd0, width_ff} > 32'(MAX_WIDTH)) begin
         last_col_idx = CW'(MAX_WIDTH - 1);
      end else begin
         last_col_idx = CW'(width_ff - 12'd1);
      end
      last_row_idx = (height_ff == 16'd0) ? 16'd0 : (height_ff - 16'd1);
   end

   // front: position and control of the incoming word
   assign acc       = req_valid && adv;
   assign req_stall = !adv;
   assign last_col  = col_ff >= last_col_idx;
   assign last_row  = row_ff >= last_row_idx;
   assign prev_row  = row_ff - 16'd1;
   assign col_nx    = (col_ff == CW'(MAX_WIDTH - 1)) ? '0 : (col_ff + CW'(1));

   always_comb begin
      ctrl0.row      = row_ff;
      ctrl0.col      = 11'(col_ff);
      ctrl0.emit_a   = row_ff != 16'd0;
      ctrl0.emit_b   = last_row;
      ctrl0.border_a = (prev_row == 16'd0) || (prev_row >= last_row_idx) ||
                       (col_ff == '0) || last_col;
      ctrl0.last_col = last_col;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (acc) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? 16'd0 : (row_ff + 16'd1);
         end else begin
            col_in = col_ff + CW'(1);
         end
      end
   end

   // line buffers: read first, write the row above back one stage later
   always_ff @(posedge clock) begin
      if (acc) begin
         above_mem[col_ff] <= req_word;
      end
      if (adv) begin
         above_ff <= above_mem[col_ff];
         right_ff <= above_mem[col_nx];
      end
   end

   always_ff @(posedge clock) begin
      if (adv && valid1_ff) begin
         two_mem[addr1_ff] <= above_ff;
      end
      if (adv) begin
         two_ff <= two_mem[col_ff];
      end
   end

   // stage 1: gradient sum
   assign two_px = fwd_ff ? fwd_px_ff : two_ff;

   always_comb begin
      sum1 = 11'(rgem_pkg::absdiff(px1_ff.red,   two_px.red))   +
             11'(rgem_pkg::absdiff(px1_ff.green, two_px.green)) +
             11'(rgem_pkg::absdiff(px1_ff.blue,  two_px.blue))  +
             11'(rgem_pkg::absdiff(right_ff.red,   held_ff.red))   +
             11'(rgem_pkg::absdiff(right_ff.green, held_ff.green)) +
             11'(rgem_pkg::absdiff(right_ff.blue,  held_ff.blue));
      if (ctrl1_ff.border_a) begin
         sum1 = 11'd0;
      end
   end

   // stage 2: scale to Q1.16
   assign prod2   = rgem_pkg::PROD_W'(sum2_ff) * rgem_pkg::PROD_W'(rgem_pkg::RECIP);
   assign energy2 = ctrl2_ff.border_a ? rgem_pkg::ONE_Q16 :
                    prod2[rgem_pkg::RECIP_SHIFT +: 17];

   // stage 3: output register, none, one or two results per word
   assign sel_b     = !ctrl3_ff.emit_a || phase_ff;
   assign last_pend = sel_b || !ctrl3_ff.emit_b;
   assign adv       = !valid3_ff || (!rsp_stall && last_pend);

   always_comb begin
      valid3_in = valid3_ff;
      phase_in  = phase_ff;
      if (adv) begin
         valid3_in = valid2_ff && (ctrl2_ff.emit_a || ctrl2_ff.emit_b);
         phase_in  = 1'b0;
      end else if (valid3_ff && !rsp_stall) begin
         phase_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= rgem_pkg::WIDTH_RESET;
         height_ff <= rgem_pkg::HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= 16'd0;
         valid1_ff <= 1'b0;
         fwd_ff    <= 1'b0;
         held_ff   <= '0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
         phase_ff  <= 1'b0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
         valid3_ff <= valid3_in;
         phase_ff  <= phase_in;
         if (adv) begin
            valid1_ff <= acc;
            fwd_ff    <= valid1_ff && (addr1_ff == col_ff);
            valid2_ff <= valid1_ff;
            if (valid1_ff) begin
               held_ff <= above_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ctrl1_ff   <= ctrl0;
         px1_ff     <= req_word;
         addr1_ff   <= col_ff;
         fwd_px_ff  <= above_ff;
         ctrl2_ff   <= ctrl1_ff;
         sum2_ff    <= sum1;
         ctrl3_ff   <= ctrl2_ff;
         sum3_ff    <= sum2_ff;
         energy3_ff <= energy2;
      end
   end

   assign rsp_valid = valid3_ff;

   always_comb begin
      rsp_word.out_col = ctrl3_ff.col;
      if (sel_b) begin
         rsp_word.out_row      = ctrl3_ff.row;
         rsp_word.gradient_sum = 11'd0;
         rsp_word.energy_q16   = rgem_pkg::ONE_Q16;
         rsp_word.on_border    = 1'b1;
         rsp_word.frame_end    = ctrl3_ff.last_col;
         rsp_word.last_of_run  = 1'b1;
      end else begin
         rsp_word.out_row      = ctrl3_ff.row - 16'd1;
         rsp_word.gradient_sum = sum3_ff;
         rsp_word.energy_q16   = energy3_ff;
         rsp_word.on_border    = ctrl3_ff.border_a;
         rsp_word.frame_end    = 1'b0;
         rsp_word.last_of_run  = !ctrl3_ff.emit_b;
      end
   end

   `RGEM_ASSERT_IMP(a_stall_blocks_input, clock, reset, rsp_valid && rsp_stall, req_stall)
   `RGEM_ASSERT_IMP(a_second_needs_both, clock, reset, valid3_ff && phase_ff, ctrl3_ff.emit_a && ctrl3_ff.emit_b)
   `RGEM_ASSERT_NXT(a_frame_wrap, clock, reset, acc && last_col && last_row, (col_ff == '0) && (row_ff == 16'd0))
   `RGEM_ASSERT_IMP(a_energy_range, clock, reset, valid3_ff, energy3_ff <= rgem_pkg::ONE_Q16)

endmodule

FILE: sim/tb_rgb_gradient_energy_map.sv
`timescale 1ns / 1ps
// Testbench for rgb_gradient_energy_map: raster frames in, energy words out.
// Predicts every result word from its own line buffers; depends on rgem_pkg.
module tb_rgb_gradient_energy_map;

   localparam int          LINE_DEPTH  = rgem_pkg::MAX_WIDTH_DFLT;
   localparam int unsigned CYCLE_LIMIT = 1500000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   rgem_pkg::req_word_type  req_word = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rgem_pkg::rsp_word_type  rsp_word;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   rgem_pkg::csr_index_type csr_index = rgem_pkg::CSR_IMAGE_WIDTH;
   logic [15:0]             csr_data = '0;

   rgem_pkg::req_word_type  pixel_queue[$];
   rgem_pkg::rsp_word_type  energy_queue[$];
   int unsigned   pixels_sent = 0;
   int unsigned   pixels_taken = 0;
   int unsigned   mismatch_count = 0;
   int unsigned   result_count = 0;
   int unsigned   cycle_count = 0;
   int unsigned   gap_left = 0;
   int unsigned   stall_left = 0;
   bit            send_calm = 1'b0;
   bit            recv_calm = 1'b0;

   bit [23:0]     prev_row_px[LINE_DEPTH];
   bit [23:0]     prev2_row_px[LINE_DEPTH];
   bit [23:0]     left_above_px = '0;
   int unsigned   col_pos = 0;
   int unsigned   row_pos = 0;
   int unsigned   img_width = rgem_pkg::WIDTH_RESET;
   int unsigned   img_height = rgem_pkg::HEIGHT_RESET;

   rgb_gradient_energy_map dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #6 clock = ~clock;

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   task automatic predict_energy(input rgem_pkg::req_word_type pixel);
      int unsigned  w, h, c, r, pr, sum, a, b, k;
      bit           last_col, last_row, border;
      bit [23:0]    px, above_here, up, right;
      rgem_pkg::rsp_word_type res;
      px = pixel;
      w = (img_width == 0) ? 1 : img_width;
      if (w > LINE_DEPTH)
         w = LINE_DEPTH;
      h = (img_height == 0) ? 1 : img_height;
      c = col_pos % LINE_DEPTH;
      r = row_pos;
      last_col = c >= w - 1;
      last_row = r >= h - 1;
      above_here = prev_row_px[c];
      if (r >= 1) begin
         pr = r - 1;
         border = pr == 0 || pr >= h - 1 || c == 0 || last_col;
         sum = 0;
         if (!border) begin
            up = prev2_row_px[c];
            right = prev_row_px[(c + 1) % LINE_DEPTH];
            for (k = 0; k < 3; k++) begin
               a = px[8*k +: 8];
               b = up[8*k +: 8];
               sum += (a > b) ? a - b : b - a;
               a = right[8*k +: 8];
               b = left_above_px[8*k +: 8];
               sum += (a > b) ? a - b : b - a;
            end
         end
         res.out_row      = 16'(pr);
         res.out_col      = 11'(c);
         res.gradient_sum = border ? 11'd0 : 11'(sum);
         res.energy_q16   = border ? rgem_pkg::ONE_Q16 :
                            17'((64'(sum) << 16) / 64'(rgem_pkg::FULL_DELTA));
         res.on_border    = border;
         res.frame_end    = 1'b0;
         res.last_of_run  = !last_row;
         energy_queue.push_back(res);
      end
      if (last_row) begin
         res.out_row      = 16'(r);
         res.out_col      = 11'(c);
         res.gradient_sum = 11'd0;
         res.energy_q16   = rgem_pkg::ONE_Q16;
         res.on_border    = 1'b1;
         res.frame_end    = last_col;
         res.last_of_run  = 1'b1;
         energy_queue.push_back(res);
      end
      prev2_row_px[c] = above_here;
      prev_row_px[c] = px;
      left_above_px = above_here;
      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
         col_pos = c + 1;
      end
   endtask

   task automatic check_energy(input rgem_pkg::rsp_word_type got);
      rgem_pkg::rsp_word_type want;
      if (energy_queue.size() == 0) begin
         if (mismatch_count < 10)
            $display("result %0d: none expected, got row %0d col %0d", result_count,
               got.out_row, got.out_col);
         mismatch_count++;
      end else begin
         want = energy_queue.pop_front();
         if (got.out_row !== want.out_row || got.out_col !== want.out_col ||
             got.gradient_sum !== want.gradient_sum || got.energy_q16 !== want.energy_q16 ||
             got.on_border !== want.on_border || got.frame_end !== want.frame_end ||
             got.last_of_run !== want.last_of_run) begin
            if (mismatch_count < 10) begin
               $display("result %0d: exp row %0d col %0d sum %0d q16 %0d brd %b end %b last %b",
                  result_count, want.out_row, want.out_col, want.gradient_sum,
                  want.energy_q16, want.on_border, want.frame_end, want.last_of_run);
               $display("result %0d: got row %0d col %0d sum %0d q16 %0d brd %b end %b last %b",
                  result_count, got.out_row, got.out_col, got.gradient_sum,
                  got.energy_q16, got.on_border, got.frame_end, got.last_of_run);
            end
            mismatch_count++;
         end
      end
      result_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else begin
         if ($urandom_range(0, 199) == 0)
            send_calm <= !send_calm;
         if (req_valid && !req_stall) begin
            predict_energy(req_word);
            pixels_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_left != 0 || pixel_queue.size() == 0) begin
               req_valid <= 1'b0;
               if (gap_left != 0)
                  gap_left <= gap_left - 1;
            end else begin
               req_word <= pixel_queue.pop_front();
               req_valid <= 1'b1;
               gap_left <= pick_gap(send_calm);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            check_energy(rsp_word);
         if ($urandom_range(0, 199) == 0)
            recv_calm <= !recv_calm;
         if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left <= stall_left - 1;
         end else if (!recv_calm && $urandom_range(0, 4) == 0) begin
            rsp_stall <= 1'b1;
            stall_left <= pick_gap(1'b0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rgb_gradient_energy_map: mismatch");
         $finish;
      end
   end

   task automatic push_pixel(input rgem_pkg::req_word_type px);
      pixel_queue.push_back(px);
      pixels_sent++;
   endtask

   function automatic rgem_pkg::req_word_type random_pixel();
      rgem_pkg::req_word_type px;
      int unsigned  k, roll;
      logic [7:0]   ch[3];
      for (k = 0; k < 3; k++) begin
         roll = $urandom_range(0, 9);
         ch[k] = (roll < 2) ? 8'h00 : (roll < 4) ? 8'hFF : 8'($urandom_range(0, 255));
      end
      px.red = ch[0];
      px.green = ch[1];
      px.blue = ch[2];
      return px;
   endfunction

   task automatic drain();
      while (pixels_taken != pixels_sent || energy_queue.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_reg(input rgem_pkg::csr_index_type idx, input logic [15:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == rgem_pkg::CSR_IMAGE_WIDTH)
         img_width = data[11:0];
      else
         img_height = data;
   endtask

   // hold until idle, then load new geometry
   task automatic set_frame(input int unsigned w, input int unsigned h);
      drain();
      repeat (10) @(posedge clock);
      write_reg(rgem_pkg::CSR_IMAGE_WIDTH, {4'($urandom_range(0, 15)), 12'(w)});
      write_reg(rgem_pkg::CSR_IMAGE_HEIGHT, 16'(h));
   endtask

   task automatic push_random(input int unsigned count);
      int unsigned n;
      for (n = 0; n < count; n++)
         push_pixel(random_pixel());
   endtask

   initial begin
      int unsigned w, h, roll, total, cut, n, random_items;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // start a row at reset geometry, then shrink it mid-row
      push_random(3);
      set_frame(4, 3);
      push_random(9);

      // strongest gradient up and down
      set_frame(3, 3);
      push_pixel(24'h000000); push_pixel(24'h000000); push_pixel(24'h000000);
      push_pixel(24'h000000); push_pixel(24'h808080); push_pixel(24'hFFFFFF);
      push_pixel(24'hFFFFFF); push_pixel(24'hFFFFFF); push_pixel(24'hFFFFFF);
      push_pixel(24'hFFFFFF); push_pixel(24'hFFFFFF); push_pixel(24'hFFFFFF);
      push_pixel(24'hFFFFFF); push_pixel(24'h123456); push_pixel(24'h000000);
      push_pixel(24'h000000); push_pixel(24'h000000); push_pixel(24'h000000);

      // single-row frames, zero registers read as one
      set_frame(3, 1);
      push_random(3);
      set_frame(0, 0);
      push_random(2);

      // tallest frame cut short by a lower height
      set_frame(1, 16'hFFFF);
      push_random(3);
      set_frame(1, 2);
      push_random(4);

      // narrow the width partway through a row
      set_frame(6, 3);
      push_random(10);
      set_frame(3, 3);
      push_random(4);

      // width past the line buffer saturates; a width of one then closes the row
      drain();
      repeat (10) @(posedge clock);
      write_reg(rgem_pkg::CSR_IMAGE_WIDTH, 16'hFFFF);
      write_reg(rgem_pkg::CSR_IMAGE_HEIGHT, 16'd1);
      push_random(8);
      set_frame(1, 1);
      push_random(1);

      random_items = 0;
      while (random_items < 680) begin
         roll = $urandom_range(0, 99);
         w = (roll < 70) ? $urandom_range(1, 10) :
             (roll < 92) ? $urandom_range(11, 40) : $urandom_range(41, 120);
         h = ($urandom_range(0, 99) < 75) ? $urandom_range(1, 6) : $urandom_range(7, 16);
         if (w * h > 300)
            h = (300 / w < 1) ? 1 : 300 / w;
         total = w * h;
         cut = (total > 1 && $urandom_range(0, 3) == 0) ? $urandom_range(1, total - 1)
                                                       : total;
         set_frame(w, h);
         for (n = 0; n < total; n++) begin
            if (n == cut)
               drain();
            push_pixel(random_pixel());
         end
         random_items += total;
      end

      drain();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && energy_queue.size() == 0)
         $display("rgb_gradient_energy_map: match");
      else
         $display("rgb_gradient_energy_map: mismatch");
      $finish;
   end

endmodule

FILE: rgb_gradient_energy_map.f
+incdir+hdl
hdl/rgem_pkg.sv
hdl/rgb_gradient_energy_map.sv
sim/tb_rgb_gradient_energy_map.sv
